@@ rtl/core/mtef_pkg.sv @@
package mtef_pkg;

  // Matrix geometry
  localparam int unsigned LEVELS       = 3;
  localparam int unsigned SPLIT_LEVELS = LEVELS - 1;   // digits found by division
  localparam int unsigned SIZE_W       = 9;
  localparam int unsigned DIG_W        = 8;            // one level digit, below 256
  localparam int unsigned SH_W         = $clog2(DIG_W);
  localparam int unsigned STRIDE_W     = 2 * SIZE_W - 1;
  localparam int unsigned IDX_W        = 24;
  localparam int unsigned DIV_W        = IDX_W + 1;
  localparam int unsigned NSTEP        = SPLIT_LEVELS * DIG_W;
  localparam int unsigned CNT_W        = 2;

  // Coefficient store
  localparam int unsigned COEF_DEPTH = 1024;
  localparam int unsigned ADDR_W     = $clog2(COEF_DEPTH);
  localparam int unsigned WORD_W     = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT = 3'd0,
    REG_SIZE_0      = 3'd1,
    REG_SIZE_1      = 3'd2,
    REG_SIZE_2      = 3'd3,
    REG_BAND_0      = 3'd4,
    REG_BAND_1      = 3'd5,
    REG_BAND_2      = 3'd6
  } cfg_reg_e;

  // Level set-up, right aligned: slot LEVELS-1 is the innermost level in use,
  // unused outer slots read as size 1, band 1.
  typedef struct packed {
    logic [LEVELS-1:0][SIZE_W-1:0] size;
    logic [LEVELS-1:0][SIZE_W-1:0] band;
    logic [STRIDE_W-1:0]           stride0;   // product of the two inner sizes
  } lvl_cfg_t;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] idx;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } item_t;

  // Divider pipeline payload
  typedef struct packed {
    op_e                                 op;
    logic [ADDR_W-1:0]                   idx;
    logic [WORD_W-1:0]                   word;
    logic [IDX_W-1:0]                    rem_r;
    logic [IDX_W-1:0]                    rem_c;
    logic [SPLIT_LEVELS-1:0][DIG_W-1:0]  q_r;
    logic [SPLIT_LEVELS-1:0][DIG_W-1:0]  q_c;
    logic                                err;
  } div_t;

endpackage

@@ rtl/core/mtef_digit_split.sv @@
module mtef_digit_split (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtef_pkg::lvl_cfg_t cfg_i,
  input  logic               in_valid_i,
  input  mtef_pkg::item_t    in_item_i,
  output logic               in_take_o,
  output logic               out_valid_o,
  output mtef_pkg::div_t     out_item_o,
  input  logic               out_take_i
);

  // One restoring division step on row and column; flags the index error
  // on the first step (quotient too wide) and on the first middle step
  // (outer digit not below the outer size).
  function automatic mtef_pkg::div_t div_step(
    input mtef_pkg::div_t                     s,
    input mtef_pkg::lvl_cfg_t                 c,
    input logic                               lvl,
    input logic [mtef_pkg::SH_W-1:0]          sh,
    input logic                               first,
    input logic                               mid
  );
    mtef_pkg::div_t                  o;
    logic [mtef_pkg::DIV_W-1:0]      dvs;
    logic [mtef_pkg::DIV_W-1:0]      lim;
    o   = s;
    dvs = (lvl ? mtef_pkg::DIV_W'(c.size[mtef_pkg::LEVELS-1])
               : mtef_pkg::DIV_W'(c.stride0)) << sh;
    lim = mtef_pkg::DIV_W'(c.stride0) << mtef_pkg::DIG_W;
    if (first) begin
      o.err = ({1'b0, s.rem_r} >= lim) || ({1'b0, s.rem_c} >= lim);
    end
    if (mid) begin
      o.err = s.err
           || (mtef_pkg::SIZE_W'(s.q_r[0]) >= c.size[0])
           || (mtef_pkg::SIZE_W'(s.q_c[0]) >= c.size[0]);
    end
    if ({1'b0, s.rem_r} >= dvs) begin
      o.rem_r          = s.rem_r - dvs[mtef_pkg::IDX_W-1:0];
      o.q_r[lvl][sh]   = 1'b1;
    end
    if ({1'b0, s.rem_c} >= dvs) begin
      o.rem_c          = s.rem_c - dvs[mtef_pkg::IDX_W-1:0];
      o.q_c[lvl][sh]   = 1'b1;
    end
    return o;
  endfunction

  logic [mtef_pkg::NSTEP:0] v_q;
  logic [mtef_pkg::NSTEP:0] take;
  mtef_pkg::div_t           div_q  [0:mtef_pkg::NSTEP];
  mtef_pkg::div_t           step_d [1:mtef_pkg::NSTEP];

  // Stage take chain: a stage moves when it is empty or its successor moves
  always_comb begin
    take[mtef_pkg::NSTEP] = !v_q[mtef_pkg::NSTEP] || out_take_i;
    for (int k = mtef_pkg::NSTEP - 1; k >= 0; k--) begin
      take[k] = !v_q[k] || take[k+1];
    end
  end

  // One quotient bit per stage, outer digit first, MSB first
  for (genvar j = 1; j <= mtef_pkg::NSTEP; j++) begin : g_step
    localparam int unsigned LVL = (j - 1) / mtef_pkg::DIG_W;
    localparam int unsigned SH  = mtef_pkg::DIG_W - 1 - (j - 1) % mtef_pkg::DIG_W;
    assign step_d[j] = div_step(div_q[j-1], cfg_i, 1'(LVL), mtef_pkg::SH_W'(SH),
                                j == 1, j == mtef_pkg::DIG_W + 1);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= mtef_pkg::NSTEP; k++) begin
        if (take[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      div_q[0].op    <= in_item_i.op;
      div_q[0].idx   <= in_item_i.idx;
      div_q[0].word  <= in_item_i.word;
      div_q[0].rem_r <= in_item_i.row;
      div_q[0].rem_c <= in_item_i.col;
      div_q[0].q_r   <= '0;
      div_q[0].q_c   <= '0;
      div_q[0].err   <= 1'b0;
    end
    for (int k = 1; k <= mtef_pkg::NSTEP; k++) begin
      if (take[k]) begin
        div_q[k] <= step_d[k];
      end
    end
  end

  assign in_take_o   = take[0];
  assign out_valid_o = v_q[mtef_pkg::NSTEP];
  assign out_item_o  = div_q[mtef_pkg::NSTEP];

endmodule

@@ rtl/core/multilevel_toeplitz_element_fetch_unit.sv @@
// Throughput: one item per cycle while the output is not stalled; 16 divider
// stages each settle one quotient bit of a level digit, then difference, two
// address stages and the RAM read. Stalls back up stage by stage; empty
// stages keep filling.
// Reset clears valid bits and sets the level registers to their defaults;
// the coefficient RAM is not cleared and holds garbage until loaded.
module multilevel_toeplitz_element_fetch_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [mtef_pkg::ADDR_W-1:0]       coef_index_i,
  input  logic [mtef_pkg::WORD_W-1:0]       coef_word_i,
  input  logic [mtef_pkg::IDX_W-1:0]        row_i,
  input  logic [mtef_pkg::IDX_W-1:0]        col_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mtef_pkg::WORD_W-1:0]       element_o,
  output logic                              in_band_o,
  output logic                              index_error_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mtef_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mtef_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef struct packed {
    mtef_pkg::op_e                                      op;
    logic [mtef_pkg::WORD_W-1:0]                        word;
    logic                                               err;
    logic                                               inband;
    logic [mtef_pkg::LEVELS-1:0][mtef_pkg::DIG_W-1:0]   d;
    logic [mtef_pkg::ADDR_W-1:0]                        addr;
  } back_t;

  function automatic logic [mtef_pkg::DIG_W-1:0] abs_diff(
    input logic [mtef_pkg::DIG_W-1:0] a,
    input logic [mtef_pkg::DIG_W-1:0] b
  );
    return (a > b) ? a - b : b - a;
  endfunction

  // Configuration registers
  logic [mtef_pkg::CNT_W-1:0]                         lvl_cnt_q;
  logic [mtef_pkg::LEVELS-1:0][mtef_pkg::SIZE_W-1:0]  size_q;
  logic [mtef_pkg::LEVELS-1:0][mtef_pkg::SIZE_W-1:0]  band_q;
  logic [mtef_pkg::STRIDE_W-1:0]                      st0_q;
  logic [mtef_pkg::STRIDE_W-1:0]                      st0_d;
  logic [mtef_pkg::LEVELS-1:0][mtef_pkg::SIZE_W-1:0]  lvl_size;
  logic [mtef_pkg::LEVELS-1:0][mtef_pkg::SIZE_W-1:0]  lvl_band;
  mtef_pkg::lvl_cfg_t                                 cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_cnt_q <= mtef_pkg::CNT_W'(1);
      size_q    <= {mtef_pkg::LEVELS{mtef_pkg::SIZE_W'(1)}};
      band_q    <= {mtef_pkg::LEVELS{mtef_pkg::SIZE_W'(1)}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mtef_pkg::cfg_reg_e'(cfg_index_i))
        mtef_pkg::REG_LEVEL_COUNT: lvl_cnt_q <= cfg_data_i[mtef_pkg::CNT_W-1:0];
        mtef_pkg::REG_SIZE_0:      size_q[0] <= cfg_data_i;
        mtef_pkg::REG_SIZE_1:      size_q[1] <= cfg_data_i;
        mtef_pkg::REG_SIZE_2:      size_q[2] <= cfg_data_i;
        mtef_pkg::REG_BAND_0:      band_q[0] <= cfg_data_i;
        mtef_pkg::REG_BAND_1:      band_q[1] <= cfg_data_i;
        mtef_pkg::REG_BAND_2:      band_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Right-align the levels in use; a count of zero acts as one
  always_comb begin
    lvl_size = {mtef_pkg::LEVELS{mtef_pkg::SIZE_W'(1)}};
    lvl_band = {mtef_pkg::LEVELS{mtef_pkg::SIZE_W'(1)}};
    unique case (lvl_cnt_q) inside
      2'd0, 2'd1: begin
        lvl_size[2] = size_q[0];
        lvl_band[2] = band_q[0];
      end
      2'd2: begin
        lvl_size[1] = size_q[0];
        lvl_size[2] = size_q[1];
        lvl_band[1] = band_q[0];
        lvl_band[2] = band_q[1];
      end
      2'd3: begin
        lvl_size = size_q;
        lvl_band = band_q;
      end
    endcase
  end

  // Outer stride, registered; used from the first divider step on
  assign st0_d = mtef_pkg::STRIDE_W'(lvl_size[1]) * mtef_pkg::STRIDE_W'(lvl_size[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st0_q <= mtef_pkg::STRIDE_W'(1);
    end else begin
      st0_q <= st0_d;
    end
  end

  assign cfg.size    = lvl_size;
  assign cfg.band    = lvl_band;
  assign cfg.stride0 = st0_q;

  // Digit split pipeline
  mtef_pkg::item_t in_item;
  mtef_pkg::div_t  sp_item;
  logic            sp_vld;
  logic            sp_in_take;
  logic            tk_a, tk_b, tk_c, tk_m;

  assign in_item.op   = mtef_pkg::op_e'(operation_i);
  assign in_item.idx  = coef_index_i;
  assign in_item.word = coef_word_i;
  assign in_item.row  = row_i;
  assign in_item.col  = col_i;

  mtef_digit_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item),
    .in_take_o   (sp_in_take),
    .out_valid_o (sp_vld),
    .out_item_o  (sp_item),
    .out_take_i  (tk_a)
  );

  assign in_stall_o = !sp_in_take;

  // Back-end take chain
  logic  a_vld_q, b_vld_q, c_vld_q, m_vld_q;
  back_t a_q, b_q, c_q;
  back_t a_d, b_d, c_d;

  assign tk_m = !m_vld_q || !out_stall_i;
  assign tk_c = !c_vld_q || tk_m;
  assign tk_b = !b_vld_q || tk_c;
  assign tk_a = !a_vld_q || tk_b;

  // Stage A: digit differences and band check
  always_comb begin
    a_d.op     = sp_item.op;
    a_d.word   = sp_item.word;
    a_d.err    = sp_item.err;
    a_d.addr   = sp_item.idx;
    a_d.d[0]   = abs_diff(sp_item.q_r[0], sp_item.q_c[0]);
    a_d.d[1]   = abs_diff(sp_item.q_r[1], sp_item.q_c[1]);
    a_d.d[2]   = abs_diff(sp_item.rem_r[mtef_pkg::DIG_W-1:0],
                          sp_item.rem_c[mtef_pkg::DIG_W-1:0]);
    a_d.inband = 1'b1;
    for (int k = 0; k < mtef_pkg::LEVELS; k++) begin
      if (mtef_pkg::SIZE_W'(a_d.d[k]) >= cfg.band[k]) begin
        a_d.inband = 1'b0;
      end
    end
  end

  // Stage B: outer part of a read's store address, modulo the store depth
  always_comb begin
    b_d = a_q;
    if (a_q.op == mtef_pkg::OP_READ) begin
      b_d.addr = mtef_pkg::ADDR_W'(mtef_pkg::ADDR_W'(a_q.d[0])
                                   * mtef_pkg::ADDR_W'(cfg.band[1])
                                   + mtef_pkg::ADDR_W'(a_q.d[1]));
    end
  end

  // Stage C: inner part of a read's store address
  always_comb begin
    c_d = b_q;
    if (b_q.op == mtef_pkg::OP_READ) begin
      c_d.addr = mtef_pkg::ADDR_W'(b_q.addr * mtef_pkg::ADDR_W'(cfg.band[2])
                                   + mtef_pkg::ADDR_W'(b_q.d[2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      if (tk_a) a_vld_q <= sp_vld;
      if (tk_b) b_vld_q <= a_vld_q;
      if (tk_c) c_vld_q <= b_vld_q;
      if (tk_m) m_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tk_a) a_q <= a_d;
    if (tk_b) b_q <= b_d;
    if (tk_c) c_q <= c_d;
  end

  // Stage M: coefficient RAM, write for loads, registered read for all
  logic [mtef_pkg::WORD_W-1:0] coef_mem_q [mtef_pkg::COEF_DEPTH];
  logic [mtef_pkg::WORD_W-1:0] rd_q;
  mtef_pkg::op_e               m_op_q;
  logic                        m_err_q;
  logic                        m_inband_q;
  logic                        m_hit;

  always_ff @(posedge clk_i) begin
    if (tk_m && c_vld_q && (c_q.op == mtef_pkg::OP_LOAD)) begin
      coef_mem_q[c_q.addr] <= c_q.word;
    end
    if (tk_m) begin
      rd_q       <= coef_mem_q[c_q.addr];
      m_op_q     <= c_q.op;
      m_err_q    <= c_q.err;
      m_inband_q <= c_q.inband;
    end
  end

  // Result
  assign m_hit         = (m_op_q == mtef_pkg::OP_READ) && !m_err_q && m_inband_q;
  assign out_valid_o   = m_vld_q;
  assign element_o     = m_hit ? rd_q : '0;
  assign in_band_o     = m_hit;
  assign index_error_o = (m_op_q == mtef_pkg::OP_READ) && m_err_q;

  // Checks
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && out_stall_i |=> m_vld_q && $stable(rd_q))
    else $error("RAM read data changed under a stalled result");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled while output is free");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !c_vld_q |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule

@@ tb/tb_multilevel_toeplitz_element_fetch_unit.sv @@
module tb_multilevel_toeplitz_element_fetch_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mtef_pkg::*;

  localparam int unsigned TARGET_ITEMS = 1650;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [WORD_W-1:0] element;
    logic              in_band;
    logic              index_error;
  } fetch_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  // Item input
  logic              in_valid    = 1'b0;
  logic              operation   = 1'b0;
  logic [ADDR_W-1:0] coef_index  = '0;
  logic [WORD_W-1:0] coef_word   = '0;
  logic [IDX_W-1:0]  row_idx     = '0;
  logic [IDX_W-1:0]  col_idx     = '0;
  logic              in_stall_o;

  // Result output
  logic              out_valid_o;
  logic              out_stall   = 1'b0;
  logic [WORD_W-1:0] element_o;
  logic              in_band_o;
  logic              index_error_o;

  // Configuration
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cfg_ready_o;

  multilevel_toeplitz_element_fetch_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .coef_index_i  (coef_index),
    .coef_word_i   (coef_word),
    .row_i         (row_idx),
    .col_i         (col_idx),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .element_o     (element_o),
    .in_band_o     (in_band_o),
    .index_error_o (index_error_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Shadow copy of the level set-up and coefficient store
  logic [1:0]        lvl_count;
  logic [SIZE_W-1:0] lvl_size [LEVELS];
  logic [SIZE_W-1:0] lvl_band [LEVELS];
  logic [WORD_W-1:0] coef_store [COEF_DEPTH];
  bit                coef_written [COEF_DEPTH];

  fetch_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent     = 0;

  // Sender and receiver pacing
  bit          gaps_on    = 1'b1;
  int unsigned quiet_left = 0;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned free_left  = 0;
  int unsigned idle_count = 0;

  // Expected element for a row/column under the current set-up
  function automatic void predict_read(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                       output fetch_result_t res, output logic [ADDR_W-1:0] addr);
    int unsigned     levels;
    longint unsigned total, r, c, rd, cd, d, a, bd;
    longint unsigned stride [LEVELS];
    bit              all_in;
    levels = (lvl_count == 2'd0) ? 1 : int'(lvl_count);
    total  = 1;
    res    = '0;
    addr   = '0;
    for (int k = int'(levels) - 1; k >= 0; k--) begin
      stride[k] = total;
      total     = total * 64'(lvl_size[k]);
    end
    r = 64'(row);
    c = 64'(col);
    if (r >= total || c >= total) begin
      res.index_error = 1'b1;
      return;
    end
    all_in = 1'b1;
    a      = 0;
    for (int k = 0; k < int'(levels); k++) begin
      rd = r / stride[k];
      cd = c / stride[k];
      r  = r - rd * stride[k];
      c  = c - cd * stride[k];
      d  = (rd > cd) ? rd - cd : cd - rd;
      bd = 64'(lvl_band[k]);
      if (d >= bd) all_in = 1'b0;
      a = (a * bd + d) % 64'(COEF_DEPTH);
    end
    addr = a[ADDR_W-1:0];
    if (all_in) begin
      res.in_band = 1'b1;
      res.element = coef_store[addr];
    end
  endfunction

  // Gap before the next item: mostly none, some short, a few long
  function automatic int unsigned next_gap();
    int unsigned pick;
    if (!gaps_on) return 0;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and wait until it is taken; predict on acceptance
  task automatic send_item(input op_e op, input logic [ADDR_W-1:0] idx,
                           input logic [WORD_W-1:0] word,
                           input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    int unsigned       gap;
    fetch_result_t     res;
    logic [ADDR_W-1:0] a;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    coef_index <= idx;
    coef_word  <= word;
    row_idx    <= row;
    col_idx    <= col;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    if (op == OP_LOAD) begin
      coef_store[idx]   = word;
      coef_written[idx] = 1'b1;
      res = '0;
    end else begin
      predict_read(row, col, res, a);
    end
    pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_load(input logic [ADDR_W-1:0] idx, input logic [WORD_W-1:0] word);
    send_item(OP_LOAD, idx, word, IDX_W'($urandom()), IDX_W'($urandom()));
  endtask

  // Read an element; an in-band entry never loaded is loaded first
  task automatic issue_read(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    fetch_result_t     res;
    logic [ADDR_W-1:0] a;
    predict_read(row, col, res, a);
    if (res.in_band && !coef_written[a]) send_load(a, WORD_W'($urandom()));
    send_item(OP_READ, ADDR_W'($urandom()), WORD_W'($urandom()), row, col);
  endtask

  // Let the pipeline empty before the set-up changes
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      REG_LEVEL_COUNT: lvl_count   = data[1:0];
      REG_SIZE_0:      lvl_size[0] = data;
      REG_SIZE_1:      lvl_size[1] = data;
      REG_SIZE_2:      lvl_size[2] = data;
      REG_BAND_0:      lvl_band[0] = data;
      REG_BAND_1:      lvl_band[1] = data;
      REG_BAND_2:      lvl_band[2] = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] count,
                           input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                           input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] b0,
                           input logic [SIZE_W-1:0] b1, input logic [SIZE_W-1:0] b2);
    wait_idle();
    set_reg(REG_LEVEL_COUNT, CFG_DATA_W'(count));
    set_reg(REG_SIZE_0, s0);
    set_reg(REG_SIZE_1, s1);
    set_reg(REG_SIZE_2, s2);
    set_reg(REG_BAND_0, b0);
    set_reg(REG_BAND_1, b1);
    set_reg(REG_BAND_2, b2);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random level set-up, biased to small sizes, extremes now and then
  task automatic random_setting();
    logic [SIZE_W-1:0] sz [LEVELS];
    logic [SIZE_W-1:0] bd [LEVELS];
    int unsigned       p, q, s;
    if ($urandom_range(0, 9) == 0) begin
      configure(2'd3, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256);
      return;
    end
    for (int k = 0; k < int'(LEVELS); k++) begin
      p = $urandom_range(0, 99);
      if (p < 60)      s = $urandom_range(1, 8);
      else if (p < 85) s = $urandom_range(9, 64);
      else if (p < 97) s = $urandom_range(65, 256);
      else             s = 0;
      q = $urandom_range(0, 99);
      if (s == 0)      bd[k] = SIZE_W'($urandom_range(0, 3));
      else if (q < 70) bd[k] = SIZE_W'($urandom_range(1, s));
      else if (q < 80) bd[k] = '0;
      else if (q < 90) bd[k] = SIZE_W'(s);
      else             bd[k] = SIZE_W'((s + 4 > 256) ? 256 : s + $urandom_range(1, 4));
      sz[k] = SIZE_W'(s);
    end
    configure(2'($urandom_range(0, 3)), sz[0], sz[1], sz[2], bd[0], bd[1], bd[2]);
  endtask

  // Random read: mostly near the bands, some noise and some edges
  task automatic random_read();
    int unsigned       levels, mode, sz, bd, rd, cd, off;
    longint unsigned   r, c, total, pick;
    logic [IDX_W-1:0]  row, col;
    levels = (lvl_count == 2'd0) ? 1 : int'(lvl_count);
    total  = 1;
    for (int k = 0; k < int'(levels); k++) total = total * 64'(lvl_size[k]);
    mode = $urandom_range(0, 99);
    if (mode < 78 && total != 0) begin
      r = 0;
      c = 0;
      for (int k = 0; k < int'(levels); k++) begin
        sz = int'(lvl_size[k]);
        bd = int'(lvl_band[k]);
        rd = $urandom_range(0, sz - 1);
        if ($urandom_range(0, 7) == 0) off = $urandom_range(0, sz - 1);
        else                           off = $urandom_range(0, (bd >= sz) ? sz - 1 : bd);
        if ($urandom_range(0, 1) == 1)
          cd = (rd + off <= sz - 1) ? rd + off : ((rd >= off) ? rd - off : sz - 1);
        else
          cd = (rd >= off) ? rd - off : ((rd + off <= sz - 1) ? rd + off : 0);
        r = r * 64'(sz) + 64'(rd);
        c = c * 64'(sz) + 64'(cd);
      end
      row = r[IDX_W-1:0];
      col = c[IDX_W-1:0];
    end else if (mode < 92) begin
      row = IDX_W'($urandom());
      col = IDX_W'($urandom());
    end else begin
      pick = 64'($urandom_range(0, 3));
      case (pick)
        0:       row = '0;
        1:       row = IDX_W'(total - 1);
        2:       row = IDX_W'(total);
        default: row = '1;
      endcase
      col = ($urandom_range(0, 1) == 1) ? IDX_W'(total - 1) : IDX_W'($urandom());
    end
    issue_read(row, col);
  endtask

  // ---------------------------------------------------------------- tests

  // Default set-up after reset: a 1x1 matrix
  task automatic test_reset_defaults();
    issue_read('0, '0);
    issue_read(24'd1, '0);
    issue_read('0, 24'd1);
    send_load(10'd1023, 32'hFFFF_FFFF);
    send_load('0, '0);
    issue_read('0, '0);
  endtask

  // Largest matrix; far corners wrap the coefficient address
  task automatic test_extremes();
    configure(2'd3, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256);
    issue_read('0, '0);
    issue_read('1, '0);
    issue_read('1, '1);
    issue_read('0, '1);
  endtask

  // Zero level count, zero size, zero band, band above size
  task automatic test_special_levels();
    configure(2'd0, 9'd4, 9'd1, 9'd1, 9'd2, 9'd1, 9'd1);
    issue_read(24'd1, '0);
    issue_read(24'd3, '0);
    issue_read(24'd4, '0);
    configure(2'd2, 9'd3, 9'd0, 9'd5, 9'd3, 9'd1, 9'd5);
    issue_read('0, '0);
    configure(2'd2, 9'd4, 9'd4, 9'd1, 9'd0, 9'd2, 9'd1);
    issue_read(24'd1, 24'd1);
    configure(2'd2, 9'd3, 9'd3, 9'd1, 9'd5, 9'd2, 9'd1);
    issue_read(24'd2, 24'd7);
  endtask

  // Receiver holds off while items keep coming, so the input backs up
  task automatic test_backpressure();
    configure(2'd3, 9'd4, 9'd4, 9'd4, 9'd2, 9'd2, 9'd2);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (80) random_read();
    gaps_on  = 1'b1;
  endtask

  // Random phases, each under its own set-up
  task automatic test_random();
    int unsigned phase_len;
    while (items_sent < TARGET_ITEMS) begin
      random_setting();
      phase_len = $urandom_range(60, 160);
      for (int unsigned i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < 20) send_load(ADDR_W'($urandom()), WORD_W'($urandom()));
        else                            random_read();
      end
    end
  endtask

  // ------------------------------------------------------------ processes

  // Receiver stall: random stretches, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      out_stall <= 1'b0;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    fetch_result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual element %h in_band %b err %b",
                 $time, element_o, in_band_o, index_error_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (element_o !== want.element) begin
          $display("%0t: element: expected %h, actual %h", $time, want.element, element_o);
          mismatch_count++;
        end
        if (in_band_o !== want.in_band) begin
          $display("%0t: in_band: expected %b, actual %b", $time, want.in_band, in_band_o);
          mismatch_count++;
        end
        if (index_error_o !== want.index_error) begin
          $display("%0t: index_error: expected %b, actual %b",
                   $time, want.index_error, index_error_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence
  initial begin
    lvl_count = 2'd1;
    for (int k = 0; k < int'(LEVELS); k++) begin
      lvl_size[k] = 9'd1;
      lvl_band[k] = 9'd1;
    end
    for (int i = 0; i < int'(COEF_DEPTH); i++) coef_written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_special_levels();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mtef_pkg.sv
rtl/core/mtef_digit_split.sv
rtl/core/multilevel_toeplitz_element_fetch_unit.sv
tb/tb_multilevel_toeplitz_element_fetch_unit.sv
